// ===== src/kbsd_pkg.sv =====
// Shared types and constants for the keyed byte stream cipher.
package kbsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KEY_W    = 64;
    localparam int KEY_ALL  = 2 * KEY_W;
    localparam int MAX_KEYB = KEY_ALL / BYTE_W;

    typedef logic [BYTE_W-1:0] t_byte_val;
    typedef logic [KEY_W-1:0]  t_key_word;

    typedef enum logic {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } t_cfg_addr;

    typedef struct packed {
        logic      last;
        t_byte_val data;
    } t_byte;

endpackage

// ===== src/kbsd_cipher.sv =====
// Key registers, rotating key ring, position counter and keystream XOR.
module kbsd_cipher #(
    parameter int KEY_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  kbsd_pkg::t_cfg_addr i_cfg_addr,
    input  kbsd_pkg::t_key_word i_cfg_wdata,
    input  logic              i_take,
    input  kbsd_pkg::t_byte   i_item,
    output kbsd_pkg::t_byte   o_result
);
    import kbsd_pkg::*;

    localparam int PW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(KEY_BYTES - 1);

    t_key_word            r_key_low;
    t_key_word            r_key_high;
    t_key_word            n_key_low;
    t_key_word            n_key_high;
    logic [KEY_ALL-1:0]   n_key_all;
    t_byte_val            r_ring [KEY_BYTES];
    t_byte_val            r_base;
    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        n_pos;
    logic [BYTE_W+PW-1:0] w_prod;
    t_byte_val            w_sum;
    t_byte_val            w_new;

    always_comb begin
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_LOW:  n_key_low  = i_cfg_wdata;
                CFG_KEY_HIGH: n_key_high = i_cfg_wdata;
                default: ;
            endcase
        end
        n_key_all = {n_key_high, n_key_low};
    end

    assign w_prod = (BYTE_W+PW)'(r_base) * (BYTE_W+PW)'(r_pos);
    assign w_sum  = r_ring[0] + r_ring[(KEY_BYTES > 1) ? 1 : 0];
    assign w_new  = (w_sum == '0) ? t_byte_val'(1) : w_sum;
    assign n_pos  = (r_pos == LAST_POS) ? '0 : r_pos + PW'(1);

    always_comb begin
        o_result.last = i_item.last;
        o_result.data = i_item.data ^ r_ring[0] ^ w_prod[BYTE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_pos      <= '0;
            r_base     <= '0;
            for (int j = 0; j < KEY_BYTES; j++) begin
                r_ring[j] <= '0;
            end
        end else if (i_cfg_we || (i_take && i_item.last)) begin
            // reload ring from key and restart at position zero
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            r_pos      <= '0;
            r_base     <= n_key_all[BYTE_W-1:0];
            for (int j = 0; j < KEY_BYTES; j++) begin
                r_ring[j] <= n_key_all[BYTE_W*j +: BYTE_W];
            end
        end else if (i_take) begin
            // update head, rotate ring by one
            r_pos <= n_pos;
            if (r_pos == '0) begin
                r_base <= w_new;
            end
            for (int j = 0; j < KEY_BYTES - 1; j++) begin
                r_ring[j] <= r_ring[j+1];
            end
            r_ring[KEY_BYTES-1] <= w_new;
        end
    end

endmodule

// ===== src/kbsd_out_reg.sv =====
// Output register stage with flow-through ready.
module kbsd_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  kbsd_pkg::t_byte i_item,
    output logic            o_ready,
    output logic            o_valid,
    output kbsd_pkg::t_byte o_item,
    input  logic            i_ready
);
    import kbsd_pkg::*;

    logic  r_valid;
    t_byte r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/keyed_byte_stream_decrypt.sv =====
// Top level of the keyed byte stream cipher.
// Symmetric byte stream cipher: the same transform encrypts and decrypts. One byte
// is taken per clock cycle and its result appears in the output register on the
// next cycle; the rate is set by the keystream step (an 8x4 multiply,
// a byte add and a one-place rotation of the key ring). Input is accepted while the
// output register is empty or being drained. Write the key only while the stream
// is idle; a key write or a byte marked tlast reloads the key ring and restarts at
// position zero. Key bytes at index KEY_BYTES and above are ignored.
module keyed_byte_stream_decrypt #(
    parameter int KEY_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  kbsd_pkg::t_cfg_addr i_cfg_addr,
    input  kbsd_pkg::t_key_word i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_in
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] data_out
    output logic                m_axis_tlast
);
    import kbsd_pkg::*;

    t_byte w_in;
    t_byte w_res;
    t_byte w_out;
    logic  w_take;

    assign w_in.data = s_axis_tdata;
    assign w_in.last = s_axis_tlast;
    assign w_take    = s_axis_tvalid && s_axis_tready;

    kbsd_cipher #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cipher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_item      (w_in),
        .o_result    (w_res)
    );

    kbsd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (w_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_item  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_out.data;
    assign m_axis_tlast = w_out.last;

endmodule

// ===== src/kbsd_checker.sv =====
// Port-level assertions for the keyed byte stream cipher, bound to the top level.
module kbsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled transaction changed");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=>
            m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast)))
        else $error("accepted transaction gave no matching result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result blocked");

endmodule

bind keyed_byte_stream_decrypt kbsd_checker u_kbsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_keyed_byte_stream_decrypt.sv =====
// Self-checking testbench for the keyed byte stream cipher: predicted bytes versus the stream.
module tb_keyed_byte_stream_decrypt;
    timeunit 1ns;
    timeprecision 1ps;

    import kbsd_pkg::*;

    localparam int KEYB        = 16;
    localparam int TOTAL_ITEMS = 1550;
    localparam int HOLD_CYCLES = 300;

    class byte_cipher_scoreboard;
        t_key_word   key_lo;
        t_key_word   key_hi;
        t_byte_val   ring[MAX_KEYB];
        int unsigned pos;
        t_byte       expected_q[$];
        int unsigned errors;

        function new();
            key_lo = '0;
            key_hi = '0;
            errors = 0;
            reload_ring();
        endfunction

        function void reload_ring();
            for (int k = 0; k < MAX_KEYB; k++) begin
                if (k < 8) begin
                    ring[k] = key_lo[k*8 +: 8];
                end else begin
                    ring[k] = key_hi[(k-8)*8 +: 8];
                end
            end
            pos = 0;
        endfunction

        function void write_key(t_cfg_addr addr, t_key_word value);
            if (addr == CFG_KEY_LOW) begin
                key_lo = value;
            end else begin
                key_hi = value;
            end
            reload_ring();
        endfunction

        function void note_byte(t_byte_val din, logic lin);
            int unsigned i;
            t_byte_val   nxt;
            t_byte_val   sum;
            t_byte       res;
            i = pos;
            if (i >= KEYB) begin
                i = 0;
            end
            res.data = din ^ ring[i] ^ t_byte_val'(ring[0] * i);
            res.last = lin;
            expected_q.push_back(res);
            nxt = (i + 1 < KEYB) ? ring[i+1] : ring[0];
            sum = ring[i] + nxt;
            if (sum == '0) begin
                sum = 8'h01;
            end
            ring[i] = sum;
            i++;
            if (i >= KEYB) begin
                i = 0;
            end
            pos = i;
            if (lin) begin
                reload_ring();
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_byte(t_byte_val dout, logic lout);
            t_byte exp_b;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected output byte %02h last %0b", dout, lout));
            end else begin
                exp_b = expected_q.pop_front();
                if (dout !== exp_b.data) begin
                    report($sformatf("data_out %02h, predicted %02h", dout, exp_b.data));
                end
                if (lout !== exp_b.last) begin
                    report($sformatf("last_out %0b, predicted %0b", lout, exp_b.last));
                end
            end
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk         = 1'b0;
    logic      i_rst_n       = 1'b0;
    logic      i_cfg_we      = 1'b0;
    t_cfg_addr i_cfg_addr    = CFG_KEY_LOW;
    t_key_word i_cfg_wdata   = '0;
    logic      s_axis_tvalid = 1'b0;
    logic      s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic      s_axis_tlast  = 1'b0;
    logic      m_axis_tvalid;
    logic      m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic      m_axis_tlast;

    byte_cipher_scoreboard scb = new();

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit          use_gaps   = 1'b1;
    bit          hold_req   = 1'b0;

    keyed_byte_stream_decrypt #(
        .KEY_BYTES(KEYB)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                scb.check_byte(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scb.note_byte(s_axis_tdata, s_axis_tlast);
            end
            if (i_cfg_we) begin
                scb.write_key(i_cfg_addr, i_cfg_wdata);
            end
        end
    end

    function automatic t_byte_val rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_byte_val'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_key_word rand_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8080_8080_8080_8080;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_byte(input t_byte_val d, input logic l);
        int unsigned gap;
        if (use_gaps && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (scb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_key(input t_cfg_addr addr, input t_key_word value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int unsigned len, input bit with_last);
        logic l;
        for (int unsigned n = 0; n < len; n++) begin
            l = (with_last && n == len - 1) || ($urandom_range(0, 39) == 0);
            send_byte(rand_byte(), l);
        end
    endtask

    initial begin
        int mode_left;
        int mode;
        mode_left = 0;
        mode      = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int unsigned phase;
        int unsigned phase_end;
        int unsigned len;
        t_cfg_addr   first_addr;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero key: every ring update saturates to one
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain_stream();

        // full wrap of the ring, with a byte pair that sums to zero
        write_key(CFG_KEY_LOW, '1);
        write_key(CFG_KEY_HIGH, 64'h8080_8080_8080_8080);
        for (int n = 0; n < 18; n++) begin
            send_byte(n[0] ? 8'hFF : 8'h00, n == 17);
        end
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        drain_stream();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            first_addr = t_cfg_addr'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: write_key(first_addr, rand_key());
                1: write_key(first_addr, rand_key());
                default: begin
                    write_key(first_addr, rand_key());
                    write_key(first_addr == CFG_KEY_LOW ? CFG_KEY_HIGH : CFG_KEY_LOW,
                              rand_key());
                end
            endcase
            use_gaps  = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                use_gaps = 1'b0;
                hold_req = 1'b1;
            end
            phase_end = items_sent + $urandom_range(40, 160);
            while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
                len = $urandom_range(1, 40);
                send_message(len, $urandom_range(0, 7) != 0);
            end
            drain_stream();
            phase++;
        end

        drain_stream();
        repeat (10) @(negedge i_clk);
        if (scb.errors == 0 && scb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
